// File: sv/pqh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqh_pkg
// Modular arithmetic helpers for the palindrome hash engine (prime 1e9+7).
// ----------------------------------------------------------------------------
package pqh_pkg;

  localparam int HW = 30;
  localparam logic [HW-1:0] HASH_PRIME = 30'd1000000007;
  localparam logic [4:0]    LETTER_MAX = 5'd25;

  typedef enum logic {OP_SET = 1'b0, OP_QUERY = 1'b1} opcode_e;

  // (x + y) mod p, both inputs below p
  function automatic logic [HW-1:0] mod_add(input logic [HW-1:0] x, input logic [HW-1:0] y);
    logic [HW:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, HASH_PRIME}) s = s - {1'b0, HASH_PRIME};
    return s[HW-1:0];
  endfunction

  // (x - y) mod p, both inputs below p
  function automatic logic [HW-1:0] mod_sub(input logic [HW-1:0] x, input logic [HW-1:0] y);
    logic [HW-1:0] r;
    if (x >= y) r = x - y;
    else r = x + (HASH_PRIME - y);
    return r;
  endfunction

  // x / 2 mod p
  function automatic logic [HW-1:0] mod_half(input logic [HW-1:0] x);
    logic [HW:0] s;
    s = x[0] ? ({1'b0, x} + {1'b0, HASH_PRIME}) : {1'b0, x};
    return s[HW:1];
  endfunction

endpackage

// File: sv/palindrome_query_hash_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palindrome_query_hash_engine
// Letter store plus forward and mirrored prefix hashes (base 32 mod 1e9+7),
// kept in two Fenwick trees in RAM; answers range palindrome queries.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake             Payload
// config    in         cfg_we_i              cfg_data_i (string_length)
// command   in         start && !busy        opcode_i first_pos_i last_pos_i new_letter_i
// result    out        done_o (one cycle)    is_palindrome_o range_error_o
//
// A set does two 30-bit bit-serial modular multiplies plus a read/write
// pair per tree level in each Fenwick tree.
// A query does four prefix walks and two multiplies. A bad range raises
// done_o with range_error_o straight from idle; an invalid set is ignored.
// After reset a clearing pass zeroes the RAMs and fills the power tables,
// one modular doubling and halving per cycle; busy stays high meanwhile.
// Results cannot be stalled.
// ----------------------------------------------------------------------------
module palindrome_query_hash_engine #(
  parameter int MAX_LENGTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_data_i,
  input  logic        start,
  output logic        busy,
  input  logic        opcode_i,
  input  logic [11:0] first_pos_i,
  input  logic [11:0] last_pos_i,
  input  logic [4:0]  new_letter_i,
  output logic        done_o,
  output logic        is_palindrome_o,
  output logic        range_error_o
);
  import pqh_pkg::*;

  localparam int AW = $clog2(MAX_LENGTH);
  localparam int LW = (AW + 2 > 13) ? AW + 2 : 13;
  localparam logic [LW-1:0] NMAX = LW'(MAX_LENGTH);
  localparam logic [AW-1:0] CLR_LAST = AW'(MAX_LENGTH - 1);
  localparam logic [LW-1:0] ONE = LW'(1);
  localparam logic [2:0]    DBL_LAST = 3'd4;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_SEQ, ST_MUL, ST_W_RD, ST_W_OP
  } state_e;

  state_e        state_q;
  logic [3:0]    step_q;
  logic [AW-1:0] clr_q;
  logic [2:0]    dbl_cnt_q;
  logic [HW-1:0] pw_q, ipw_q;
  logic [12:0]   len_q;
  logic          op_q;
  logic [LW-1:0] a_q, b_q, n_q, i_q;
  logic [4:0]    nv_q;
  logic [HW-1:0] diff_q, df_q, dr_q, hf_q, acc_q;
  logic [HW-1:0] m_a_q, m_b_q, m_r_q;
  logic [4:0]    m_cnt_q;
  logic          upd_q, sub_q, tsel_q;
  logic [AW-1:0] let_ra_q, pow_ra_q, ipw_ra_q, tree_ra_q;
  logic          done_q, pal_q, err_q;

  logic          clearing, pow_we;
  logic          let_we, fwd_we, rev_we;
  logic [AW-1:0] let_wa, tree_wa;
  logic [4:0]    let_wd, let_rd;
  logic [HW-1:0] tree_wd, fwd_rd, rev_rd, tree_rd, pow_rd, ipw_rd;
  logic [HW-1:0] mul_next;
  logic [HW-1:0] dbl;
  logic [LW-1:0] pos_a, pos_b, len_ext, n_eff, rk, lowbit;

  // ---- RAM write controls
  assign clearing = (state_q == ST_CLEAR);
  assign pow_we   = clearing && (dbl_cnt_q == '0);
  assign let_we   = clearing || (state_q == ST_SEQ && op_q == OP_SET && step_q == 4'd3);
  assign let_wa   = clearing ? clr_q : a_q[AW-1:0];
  assign let_wd   = clearing ? 5'd0 : nv_q;
  assign tree_rd  = tsel_q ? rev_rd : fwd_rd;
  assign tree_wa  = clearing ? clr_q : tree_ra_q;
  assign tree_wd  = clearing ? '0 : mod_add(tree_rd, acc_q);
  assign fwd_we   = clearing || (state_q == ST_W_OP && upd_q && !tsel_q);
  assign rev_we   = clearing || (state_q == ST_W_OP && upd_q && tsel_q);

  pqh_ram #(.WIDTH(5), .DEPTH(MAX_LENGTH)) u_letters (
    .clk_i, .we_i(let_we), .waddr_i(let_wa), .wdata_i(let_wd),
    .raddr_i(let_ra_q), .rdata_o(let_rd));
  pqh_ram #(.WIDTH(HW), .DEPTH(MAX_LENGTH)) u_fwd (
    .clk_i, .we_i(fwd_we), .waddr_i(tree_wa), .wdata_i(tree_wd),
    .raddr_i(tree_ra_q), .rdata_o(fwd_rd));
  pqh_ram #(.WIDTH(HW), .DEPTH(MAX_LENGTH)) u_rev (
    .clk_i, .we_i(rev_we), .waddr_i(tree_wa), .wdata_i(tree_wd),
    .raddr_i(tree_ra_q), .rdata_o(rev_rd));
  pqh_ram #(.WIDTH(HW), .DEPTH(MAX_LENGTH)) u_pow (
    .clk_i, .we_i(pow_we), .waddr_i(clr_q), .wdata_i(pw_q),
    .raddr_i(pow_ra_q), .rdata_o(pow_rd));
  pqh_ram #(.WIDTH(HW), .DEPTH(MAX_LENGTH)) u_ipow (
    .clk_i, .we_i(pow_we), .waddr_i(clr_q), .wdata_i(ipw_q),
    .raddr_i(ipw_ra_q), .rdata_o(ipw_rd));

  // ---- bit-serial modular multiply step
  always_comb begin
    dbl      = mod_add(m_r_q, m_r_q);
    mul_next = m_a_q[HW-1] ? mod_add(dbl, m_b_q) : dbl;
  end

  // ---- position arithmetic
  assign pos_a   = LW'(first_pos_i);
  assign pos_b   = LW'(last_pos_i);
  assign len_ext = LW'(len_q);
  assign n_eff   = (len_ext == '0) ? ONE : ((len_ext > NMAX) ? NMAX : len_ext);
  assign rk      = n_q - ONE - a_q;
  assign lowbit  = i_q & (~i_q + ONE);

  assign busy            = (state_q != ST_IDLE);
  assign done_o          = done_q;
  assign is_palindrome_o = pal_q;
  assign range_error_o   = err_q;

  // ---- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      step_q    <= '0;
      clr_q     <= '0;
      dbl_cnt_q <= '0;
      pw_q      <= HW'(1);
      ipw_q     <= HW'(1);
      len_q     <= 13'd4096;
      done_q    <= 1'b0;
      pal_q     <= 1'b0;
      err_q     <= 1'b0;
      m_cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) len_q <= cfg_data_i;
      unique case (state_q)
        // zero the stores, fill the power tables: times 32 and divide by 32,
        // one bit per cycle
        ST_CLEAR: begin
          pw_q  <= mod_add(pw_q, pw_q);
          ipw_q <= mod_half(ipw_q);
          if (dbl_cnt_q == DBL_LAST) begin
            dbl_cnt_q <= '0;
            clr_q     <= clr_q + AW'(1);
            if (clr_q == CLR_LAST) state_q <= ST_IDLE;
          end else begin
            dbl_cnt_q <= dbl_cnt_q + 3'd1;
          end
        end
        // take an item
        ST_IDLE: begin
          if (start) begin
            op_q     <= opcode_i;
            a_q      <= pos_a;
            b_q      <= pos_b;
            n_q      <= n_eff;
            nv_q     <= new_letter_i + 5'd1;
            let_ra_q <= pos_a[AW-1:0];
            pow_ra_q <= pos_a[AW-1:0];
            step_q   <= '0;
            if (opcode_i == OP_SET) begin
              if (pos_a < n_eff && new_letter_i <= LETTER_MAX) state_q <= ST_SEQ;
            end else if (pos_a > pos_b || pos_b >= n_eff) begin
              done_q <= 1'b1;
              pal_q  <= 1'b0;
              err_q  <= 1'b1;
            end else begin
              state_q <= ST_SEQ;
            end
          end
        end
        ST_SEQ: begin
          if (op_q == OP_SET) begin
            unique case (step_q)
              4'd0: step_q <= 4'd1;
              4'd1: begin
                diff_q   <= mod_sub(HW'(nv_q), HW'(let_rd));
                m_a_q    <= mod_sub(HW'(nv_q), HW'(let_rd));
                m_b_q    <= pow_rd;
                m_r_q    <= '0;
                m_cnt_q  <= '0;
                pow_ra_q <= rk[AW-1:0];
                step_q   <= 4'd2;
                state_q  <= ST_MUL;
              end
              4'd2: begin
                df_q    <= m_r_q;
                m_a_q   <= diff_q;
                m_b_q   <= pow_rd;
                m_r_q   <= '0;
                m_cnt_q <= '0;
                step_q  <= 4'd3;
                state_q <= ST_MUL;
              end
              4'd3: begin
                dr_q      <= m_r_q;
                acc_q     <= df_q;
                tsel_q    <= 1'b0;
                upd_q     <= 1'b1;
                i_q       <= a_q + ONE;
                tree_ra_q <= a_q[AW-1:0];
                step_q    <= 4'd4;
                state_q   <= ST_W_RD;
              end
              4'd4: begin
                acc_q     <= dr_q;
                tsel_q    <= 1'b1;
                i_q       <= rk + ONE;
                tree_ra_q <= rk[AW-1:0];
                step_q    <= 4'd5;
                state_q   <= ST_W_RD;
              end
              default: state_q <= ST_IDLE;
            endcase
          end else begin
            unique case (step_q)
              4'd0: begin
                acc_q     <= '0;
                tsel_q    <= 1'b0;
                upd_q     <= 1'b0;
                sub_q     <= 1'b0;
                i_q       <= b_q + ONE;
                tree_ra_q <= b_q[AW-1:0];
                step_q    <= 4'd1;
                state_q   <= ST_W_RD;
              end
              4'd1: begin
                ipw_ra_q <= a_q[AW-1:0];
                step_q   <= 4'd2;
                if (a_q != '0) begin
                  sub_q     <= 1'b1;
                  i_q       <= a_q;
                  tree_ra_q <= a_q[AW-1:0] - AW'(1);
                  state_q   <= ST_W_RD;
                end
              end
              4'd2: step_q <= 4'd3;
              4'd3, 4'd7: begin
                m_a_q   <= acc_q;
                m_b_q   <= ipw_rd;
                m_r_q   <= '0;
                m_cnt_q <= '0;
                step_q  <= step_q + 4'd1;
                state_q <= ST_MUL;
              end
              4'd4: begin
                hf_q      <= m_r_q;
                acc_q     <= '0;
                tsel_q    <= 1'b1;
                sub_q     <= 1'b0;
                i_q       <= n_q - a_q;
                tree_ra_q <= AW'(n_q - ONE - a_q);
                step_q    <= 4'd5;
                state_q   <= ST_W_RD;
              end
              4'd5: begin
                ipw_ra_q <= AW'(n_q - ONE - b_q);
                step_q   <= 4'd6;
                if (n_q - ONE != b_q) begin
                  sub_q     <= 1'b1;
                  i_q       <= n_q - ONE - b_q;
                  tree_ra_q <= AW'(n_q - ONE - b_q - ONE);
                  state_q   <= ST_W_RD;
                end
              end
              4'd6: step_q <= 4'd7;
              default: begin
                done_q  <= 1'b1;
                pal_q   <= (m_r_q == hf_q);
                err_q   <= 1'b0;
                state_q <= ST_IDLE;
              end
            endcase
          end
        end
        // multiply one bit per cycle, MSB first
        ST_MUL: begin
          m_r_q   <= mul_next;
          m_a_q   <= {m_a_q[HW-2:0], 1'b0};
          m_cnt_q <= m_cnt_q + 5'd1;
          if (m_cnt_q == 5'(HW - 1)) state_q <= ST_SEQ;
        end
        // wait for tree read data
        ST_W_RD: state_q <= ST_W_OP;
        // update or accumulate one tree level, then advance
        ST_W_OP: begin
          if (upd_q) begin
            if (i_q + lowbit > NMAX) begin
              state_q <= ST_SEQ;
            end else begin
              i_q       <= i_q + lowbit;
              tree_ra_q <= AW'(i_q + lowbit - ONE);
              state_q   <= ST_W_RD;
            end
          end else begin
            acc_q <= sub_q ? mod_sub(acc_q, tree_rd) : mod_add(acc_q, tree_rd);
            if (i_q - lowbit == '0) begin
              state_q <= ST_SEQ;
            end else begin
              i_q       <= i_q - lowbit;
              tree_ra_q <= AW'(i_q - lowbit - ONE);
              state_q   <= ST_W_RD;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: sv/pqh_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqh_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pqh_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write, then registered read
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
